@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file
// every property is sampled on the rising edge of clk and ignored while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication or plain property
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle, consequence in the next
`define MRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, constants and helpers of the memory region coalescer.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int TABLE_DEPTH   = 128;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W        = 64;
  localparam int PAGES_W       = 64;
  localparam int KIND_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 8;
  localparam int PAGE_SHIFT    = 12;

  // request codes
  localparam logic REQ_DESC  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // firmware memory type codes that may be usable
  localparam logic [KIND_W-1:0] KIND_BOOT_CODE    = 32'd3;
  localparam logic [KIND_W-1:0] KIND_BOOT_DATA    = 32'd4;
  localparam logic [KIND_W-1:0] KIND_CONVENTIONAL = 32'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // one table entry: byte range [base, lim)
  typedef struct packed {
    logic              usable;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lim;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RES_RD,
    S_RES_EV,
    S_COV_TEST,
    S_COV_RD,
    S_COV_EV,
    S_COV_END,
    S_DONE
  } seq_state_t;

  function automatic logic is_usable(input logic [KIND_W-1:0] kind, input logic runtime);
    logic kind_ok;
    kind_ok = kind inside {KIND_BOOT_CODE, KIND_BOOT_DATA, KIND_CONVENTIONAL};
    return kind_ok && !runtime;
  endfunction

endpackage

@@ rtl/core/mrc_ifs.sv @@
// ----------------------------------------------------------------------------
// mrc_ifs
// Request and response channels of the memory region coalescer.
// ----------------------------------------------------------------------------
interface mrc_req_if import mrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               first_of_map;
  logic               last_of_map;
  logic [ADDR_W-1:0]  region_start;
  logic [PAGES_W-1:0] page_count;
  logic [KIND_W-1:0]  region_kind;
  logic               runtime_flag;
  logic [ADDR_W-1:0]  dest_first;
  logic [ADDR_W-1:0]  dest_limit;
  logic               dest_owned;

  modport source (
    output valid, req_type, first_of_map, last_of_map, region_start, page_count,
           region_kind, runtime_flag, dest_first, dest_limit, dest_owned,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_of_map, last_of_map, region_start, page_count,
           region_kind, runtime_flag, dest_first, dest_limit, dest_owned,
    output ready
  );
endinterface

interface mrc_rsp_if import mrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic                     dest_ready;

  modport source (output valid, status, entry_count, dest_ready, input ready);
  modport sink   (input valid, status, entry_count, dest_ready, output ready);
endinterface

@@ rtl/core/mrc_ram.sv @@
// ----------------------------------------------------------------------------
// mrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/memory_region_coalescer.sv @@
// ----------------------------------------------------------------------------
// memory_region_coalescer
// Builds a table of usable and reserved byte ranges from firmware memory
// descriptors and answers destination readiness checks against it.
// ----------------------------------------------------------------------------
// Descriptors are taken one word a cycle while the sequencer is idle and the
// response slot is free: each with a nonzero in-range length is appended to
// the table, unless it is full, or merged into the last entry in the cycle it
// is accepted, and its response word is registered for the next cycle. A
// readiness check stalls the request channel while a small sequencer walks
// the table through the single read port of the entry RAM, for each entry
// first presenting the address, then evaluating it in one shared 64-bit
// compare bank. The walk is one pass for reserved overlap plus one pass per
// link of the covering chain, and a chain of n usable entries can take n + 1
// passes; an already owned destination skips the walk. Entry storage is not
// cleared at reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module memory_region_coalescer import mrc_pkg::*; (
  input logic        clk,
  input logic        rst,
  mrc_req_if.sink    req,
  mrc_rsp_if.source  rsp
);

  // sequencer and table state
  seq_state_t        state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;

  // copy of the last entry so that merging needs no read
  logic [ADDR_W-1:0] last_base, last_base_next;
  logic [ADDR_W-1:0] last_end, last_end_next;
  logic              last_usable, last_usable_next;

  // check working registers
  logic [ADDR_W-1:0] chk_first, chk_first_next;
  logic [ADDR_W-1:0] chk_limit, chk_limit_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [ADDR_W-1:0] reach, reach_next;
  logic              chk_ready, chk_ready_next;

  // response word register
  logic              out_valid, out_valid_next;
  status_t           out_status, out_status_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic              out_dest_ready, out_dest_ready_next;

  // entry ram
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data, rd_data;

  // descriptor datapath
  logic              req_acc, desc_acc, chk_acc, slot_free;
  logic [CNT_W-1:0]  cnt0, cnt0_last;
  logic [ADDR_W-1:0] headroom, len, new_end;
  logic              ovf, zero_len, usable, merge, full, take, append;
  status_t           desc_status;

  // shared compare bank for the walk
  logic              last_entry, hits_reserved, extends_reach;

  mrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // response slot frees when empty or when the current word is taken
  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign req_acc   = req.valid && req.ready;
  assign desc_acc  = req_acc && (req.req_type == REQ_DESC);
  assign chk_acc   = req_acc && (req.req_type == REQ_CHECK);

  // first of map empties the table before the descriptor is applied
  assign cnt0      = req.first_of_map ? '0 : count;
  assign cnt0_last = cnt0 - CNT_W'(1);

  // end address overflows when pages exceed (2^64 - 1 - start) / 4096
  assign headroom = (~req.region_start) >> PAGE_SHIFT;
  assign ovf      = req.page_count > headroom;
  assign len      = req.page_count << PAGE_SHIFT;
  assign zero_len = (len == '0);
  assign new_end  = req.region_start + len;
  assign usable   = is_usable(req.region_kind, req.runtime_flag);
  assign merge    = usable && (cnt0 != '0) && last_usable && (last_end == req.region_start);
  assign full     = cnt0 >= CNT_W'(TABLE_DEPTH);
  assign take     = !ovf && !zero_len;
  assign append   = take && !merge && !full;

  assign wr_en         = desc_acc && take && (merge || !full);
  assign wr_addr       = merge ? cnt0_last[IDX_W-1:0] : cnt0[IDX_W-1:0];
  assign wr_data.usable = usable;
  assign wr_data.base  = merge ? last_base : req.region_start;
  assign wr_data.lim   = new_end;

  // error priority: overflow, then full, then empty map
  always_comb begin
    if (ovf) begin
      desc_status = ST_OVERFLOW;
    end else if (take && !merge && full) begin
      desc_status = ST_FULL;
    end else if (req.last_of_map && (count_next == '0)) begin
      desc_status = ST_EMPTY;
    end else begin
      desc_status = ST_OK;
    end
  end

  assign rd_en      = (state == S_RES_RD) || (state == S_COV_RD);
  assign last_entry = (CNT_W'(idx) == (count - CNT_W'(1)));

  // reserved entry overlapping [first, limit)
  assign hits_reserved = !rd_data.usable && (chk_first < rd_data.lim) &&
                         (rd_data.base < chk_limit);
  // usable entry starting at or below the cursor and reaching further
  assign extends_reach = rd_data.usable && (rd_data.base <= cursor) &&
                         (rd_data.lim > reach);

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    count_next          = count;
    last_base_next      = last_base;
    last_end_next       = last_end;
    last_usable_next    = last_usable;
    chk_first_next      = chk_first;
    chk_limit_next      = chk_limit;
    cursor_next         = cursor;
    reach_next          = reach;
    chk_ready_next      = chk_ready;
    out_valid_next      = out_valid && !rsp.ready;
    out_status_next     = out_status;
    out_count_next      = out_count;
    out_dest_ready_next = out_dest_ready;

    if (desc_acc) begin
      count_next = cnt0 + CNT_W'(append);
    end

    case (state)
      S_IDLE: begin
        if (desc_acc) begin
          if (take && merge) begin
            last_end_next = new_end;
          end else if (append) begin
            last_base_next   = req.region_start;
            last_end_next    = new_end;
            last_usable_next = usable;
          end
          out_valid_next      = 1'b1;
          out_status_next     = desc_status;
          out_count_next      = count_next;
          out_dest_ready_next = 1'b0;
        end else if (chk_acc) begin
          chk_first_next = req.dest_first;
          chk_limit_next = req.dest_limit;
          cursor_next    = req.dest_first;
          idx_next       = '0;
          if (req.dest_owned) begin
            chk_ready_next = 1'b1;
            state_next     = S_DONE;
          end else if (count == '0) begin
            state_next = S_COV_TEST;
          end else begin
            state_next = S_RES_RD;
          end
        end
      end
      S_RES_RD: begin
        state_next = S_RES_EV;
      end
      S_RES_EV: begin
        if (hits_reserved) begin
          chk_ready_next = 1'b0;
          state_next     = S_DONE;
        end else if (last_entry) begin
          state_next = S_COV_TEST;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_RES_RD;
        end
      end
      S_COV_TEST: begin
        // covered once the cursor reaches or passes the limit
        if (!(cursor < chk_limit)) begin
          chk_ready_next = 1'b1;
          state_next     = S_DONE;
        end else if (count == '0) begin
          chk_ready_next = 1'b0;
          state_next     = S_DONE;
        end else begin
          idx_next   = '0;
          reach_next = cursor;
          state_next = S_COV_RD;
        end
      end
      S_COV_RD: begin
        state_next = S_COV_EV;
      end
      S_COV_EV: begin
        if (extends_reach) begin
          reach_next = rd_data.lim;
        end
        if (last_entry) begin
          state_next = S_COV_END;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_COV_RD;
        end
      end
      S_COV_END: begin
        // a gap in the chain fails the check
        if (reach == cursor) begin
          chk_ready_next = 1'b0;
          state_next     = S_DONE;
        end else begin
          cursor_next = reach;
          state_next  = S_COV_TEST;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_status_next     = ST_OK;
          out_count_next      = count;
          out_dest_ready_next = chk_ready;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    idx            <= idx_next;
    last_base      <= last_base_next;
    last_end       <= last_end_next;
    last_usable    <= last_usable_next;
    chk_first      <= chk_first_next;
    chk_limit      <= chk_limit_next;
    cursor         <= cursor_next;
    reach          <= reach_next;
    chk_ready      <= chk_ready_next;
    out_status     <= out_status_next;
    out_count      <= out_count_next;
    out_dest_ready <= out_dest_ready_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = ENTRY_COUNT_W'(out_count);
  assign rsp.dest_ready  = out_dest_ready;

endmodule

@@ rtl/core/mrc_checker.sv @@
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks on the response channel of the memory region coalescer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrc_checker import mrc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STATUS_W-1:0]      rsp_status,
  input logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
  input logic                     rsp_dest_ready
);

  // stalled response word holds
  `MRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count) && $stable(rsp_dest_ready), "response word changed while stalled")

  `MRC_ASSERT(a_count_bound, rsp_valid |-> rsp_entry_count <= ENTRY_COUNT_W'(TABLE_DEPTH), "entry count beyond table depth")

  `MRC_ASSERT(a_empty_zero, rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0, "empty map with entries")

  `MRC_ASSERT(a_full_count, rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == ENTRY_COUNT_W'(TABLE_DEPTH), "table full below depth")

  `MRC_ASSERT(a_ready_ok, rsp_valid && rsp_dest_ready |-> rsp_status == ST_OK, "ready check with error status")

endmodule

bind memory_region_coalescer mrc_checker u_mrc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count),
  .rsp_dest_ready  (rsp.dest_ready)
);
